// File: hdl/ppt_pkg.sv
// Shared types and constants for the projective point transform.
// No dependencies; every other file of the block imports this package.
package ppt_pkg;

    localparam int COEF_W    = 32;
    localparam int NUM_COEF  = 9;
    localparam int IDX_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int DIGIT_W   = 4;
    localparam int MUL_STEPS = COEF_W / DIGIT_W;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int QUO_W     = 32;
    localparam int NUM_ROWS  = 3;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_DIV = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT      = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_ABS,
        S_CHK,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic init;
        logic step;
    } t_div_ctl;

endpackage

// File: hdl/ppt_if.sv
// Valid/ready channel interfaces for point items and transform results.
// Depends on ppt_pkg for field widths.
interface ppt_in_if;
    import ppt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [COEF_W-1:0] point_x;
    logic signed [COEF_W-1:0] point_y;

    modport source (
        output valid, kind, coef_index, coef_value, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, kind, coef_index, coef_value, point_x, point_y,
        output ready
    );
endinterface

interface ppt_out_if;
    import ppt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [QUO_W-1:0]  result_x;
    logic signed [QUO_W-1:0]  result_y;
    logic [STATUS_W-1:0]      status;

    modport source (
        output valid, result_x, result_y, status,
        input  ready
    );
    modport sink (
        input  valid, result_x, result_y, status,
        output ready
    );
endinterface

// File: hdl/ppt_div.sv
// Bit-serial restoring divider lane: one quotient bit per cycle while step is set, fixed-point scaled.
// Depends on ppt_pkg for the quotient width and the control struct.
module ppt_div #(
    parameter int MAG_W     = 49,
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  ppt_pkg::t_div_ctl         i_ctl,
    input  logic [MAG_W-1:0]          i_num,
    input  logic [MAG_W-1:0]          i_den,
    output logic                      o_ovf,
    output logic [ppt_pkg::QUO_W-1:0] o_quo
);
    import ppt_pkg::*;

    localparam int INT_BITS = QUO_W - FRAC_BITS;

    logic [MAG_W-1:0] r_rem;
    logic [MAG_W-1:0] n_rem;
    logic [QUO_W-1:0] r_low;
    logic [QUO_W-1:0] r_quo;
    logic             r_ovf;
    logic [MAG_W:0]   w_trial;
    logic [MAG_W:0]   w_diff;
    logic             w_bit;
    logic [MAG_W-1:0] w_top;

    // The dividend is num scaled by 2^FRAC_BITS. Its bits above the low QUO_W form the
    // starting remainder; when that part reaches the divisor the quotient cannot fit.
    assign w_top = i_num >> INT_BITS;

    always_comb begin
        w_trial = {r_rem, r_low[QUO_W-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_bit   = ~w_diff[MAG_W];
        n_rem   = w_bit ? w_diff[MAG_W-1:0] : w_trial[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_rem <= w_top;
            r_low <= {i_num[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
            r_quo <= '0;
            r_ovf <= (w_top >= i_den);
        end else if (i_ctl.step) begin
            r_rem <= n_rem;
            r_low <= r_low << 1;
            r_quo <= {r_quo[QUO_W-2:0], w_bit};
        end
    end

    assign o_ovf = r_ovf;
    assign o_quo = r_quo;

endmodule

// File: hdl/projective_point_transform.sv
// Top level of the 3x3 homogeneous point transform: matrix store, serial MACs, control.
// Depends on ppt_pkg, ppt_if (ppt_in_if, ppt_out_if) and ppt_div.
//
// Usage: one input channel carries two kinds of item. A load item writes one
// column-major coefficient of the matrix and produces nothing; a load with a slot
// above eight is dropped. A point item produces exactly one result on the output
// channel: x and y divided by w in signed fixed point, with a status of ok, zero
// divisor (both results zero) or saturated.
// Flow: a point runs through radix-16 multiply-accumulate on the coordinate digits,
// then sums, takes magnitudes and checks the divisor, runs two bit-serial divider
// lanes and registers its result with sign and saturation applied; a point with w
// zero skips the divider. The input is ready only while no point is in work, so a
// new item is not taken until the last point's result has been loaded.
// Reset sets the matrix to identity and empties the output register.
// A waiting result sits in the output register; the next item is still accepted,
// and a finished point holds in its last cycle until the register frees up.
module projective_point_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ppt_in_if.sink   i_in,
    ppt_out_if.source o_out
);
    import ppt_pkg::*;

    localparam int T_W       = PROD_W + 1 - FRAC_BITS;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [COEF_W-1:0] ONE = COEF_W'(1) << FRAC_BITS;

    t_state r_state;
    t_state n_state;
    logic [CNT_W-1:0] r_cnt;

    logic signed [COEF_W-1:0] r_coef [NUM_COEF];
    logic signed [COEF_W-1:0] r_x;
    logic signed [COEF_W-1:0] r_y;
    logic signed [PROD_W-1:0] r_acc_x [NUM_ROWS];
    logic signed [PROD_W-1:0] r_acc_y [NUM_ROWS];
    logic signed [T_W-1:0]    r_t     [NUM_ROWS];
    logic [T_W-1:0]           r_mag   [NUM_ROWS];
    logic                     r_neg_x;
    logic                     r_neg_y;
    logic                     r_zero;

    logic signed [QUO_W-1:0]  r_res_x;
    logic signed [QUO_W-1:0]  r_res_y;
    logic [STATUS_W-1:0]      r_status;
    logic                     r_out_valid;

    logic                        w_in_ready;
    logic                        w_out_load;
    t_div_ctl                    w_div_ctl;
    logic                        w_accept;
    logic signed [DIGIT_W:0]     w_dx;
    logic signed [DIGIT_W:0]     w_dy;
    logic signed [COEF_W+DIGIT_W:0] w_px [NUM_ROWS];
    logic signed [COEF_W+DIGIT_W:0] w_py [NUM_ROWS];
    logic                        w_ovf_x;
    logic                        w_ovf_y;
    logic [QUO_W-1:0]            w_quo_x;
    logic [QUO_W-1:0]            w_quo_y;
    logic [QUO_W-1:0]            w_lim_x;
    logic [QUO_W-1:0]            w_lim_y;
    logic                        w_sat_x;
    logic                        w_sat_y;
    logic [QUO_W-1:0]            w_mag_x;
    logic [QUO_W-1:0]            w_mag_y;

    assign w_accept = i_in.valid && w_in_ready;

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? '0 : r_cnt + 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_in_ready = 1'b0;
        w_out_load = 1'b0;
        w_div_ctl  = '0;
        unique case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid && i_in.kind == KIND_POINT) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: n_state = S_ABS;
            S_ABS: n_state = S_CHK;
            S_CHK: begin
                w_div_ctl.init = 1'b1;
                n_state = (r_mag[2] == '0) ? S_FIN : S_DIV;
            end
            S_DIV: begin
                w_div_ctl.step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Matrix store; the diagonal slots reset to one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= (i % 4 == 0) ? ONE : '0;
            end
        end else if (w_accept && i_in.kind == KIND_LOAD
                     && i_in.coef_index < IDX_W'(NUM_COEF)) begin
            r_coef[i_in.coef_index] <= i_in.coef_value;
        end
    end

    // Digits enter most significant first; only the top digit carries the sign.
    always_comb begin
        if (r_cnt == '0) begin
            w_dx = {r_x[COEF_W-1], r_x[COEF_W-1 -: DIGIT_W]};
            w_dy = {r_y[COEF_W-1], r_y[COEF_W-1 -: DIGIT_W]};
        end else begin
            w_dx = {1'b0, r_x[COEF_W-1 -: DIGIT_W]};
            w_dy = {1'b0, r_y[COEF_W-1 -: DIGIT_W]};
        end
        for (int j = 0; j < NUM_ROWS; j++) begin
            w_px[j] = r_coef[j] * w_dx;
            w_py[j] = r_coef[j + NUM_ROWS] * w_dy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_in.point_x;
            r_y <= i_in.point_y;
            for (int j = 0; j < NUM_ROWS; j++) begin
                r_acc_x[j] <= '0;
                r_acc_y[j] <= '0;
            end
        end else if (r_state == S_MUL) begin
            r_x <= r_x << DIGIT_W;
            r_y <= r_y << DIGIT_W;
            for (int j = 0; j < NUM_ROWS; j++) begin
                r_acc_x[j] <= (r_acc_x[j] <<< DIGIT_W) + PROD_W'(w_px[j]);
                r_acc_y[j] <= (r_acc_y[j] <<< DIGIT_W) + PROD_W'(w_py[j]);
            end
        end
    end

    // Each product is floored to the fraction width on its own before the sum.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            for (int j = 0; j < NUM_ROWS; j++) begin
                r_t[j] <= T_W'(r_acc_x[j] >>> FRAC_BITS) + T_W'(r_acc_y[j] >>> FRAC_BITS)
                          + T_W'(r_coef[j + 2 * NUM_ROWS]);
            end
        end
        if (r_state == S_ABS) begin
            for (int j = 0; j < NUM_ROWS; j++) begin
                r_mag[j] <= r_t[j][T_W-1] ? T_W'(-r_t[j]) : r_t[j];
            end
            r_neg_x <= r_t[0][T_W-1] ^ r_t[2][T_W-1];
            r_neg_y <= r_t[1][T_W-1] ^ r_t[2][T_W-1];
        end
        if (r_state == S_CHK) begin
            r_zero <= (r_mag[2] == '0);
        end
    end

    ppt_div #(
        .MAG_W     (T_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_x (
        .i_clk (i_clk),
        .i_ctl (w_div_ctl),
        .i_num (r_mag[0]),
        .i_den (r_mag[2]),
        .o_ovf (w_ovf_x),
        .o_quo (w_quo_x)
    );

    ppt_div #(
        .MAG_W     (T_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_y (
        .i_clk (i_clk),
        .i_ctl (w_div_ctl),
        .i_num (r_mag[1]),
        .i_den (r_mag[2]),
        .o_ovf (w_ovf_y),
        .o_quo (w_quo_y)
    );

    // The limit on the magnitude is one larger for a negative result.
    always_comb begin
        w_lim_x = {r_neg_x, {(QUO_W-1){~r_neg_x}}};
        w_lim_y = {r_neg_y, {(QUO_W-1){~r_neg_y}}};
        w_sat_x = w_ovf_x || (w_quo_x > w_lim_x);
        w_sat_y = w_ovf_y || (w_quo_y > w_lim_y);
        w_mag_x = w_sat_x ? w_lim_x : w_quo_x;
        w_mag_y = w_sat_y ? w_lim_y : w_quo_y;
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_zero) begin
                r_res_x  <= '0;
                r_res_y  <= '0;
                r_status <= ST_ZERO_DIV;
            end else begin
                r_res_x  <= r_neg_x ? -w_mag_x : w_mag_x;
                r_res_y  <= r_neg_y ? -w_mag_y : w_mag_y;
                r_status <= (w_sat_x || w_sat_y) ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_in.ready     = w_in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.result_x = r_res_x;
    assign o_out.result_y = r_res_y;
    assign o_out.status   = r_status;

`ifndef NO_ASSERTIONS
    a_point_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.kind == KIND_POINT) |=> (r_state == S_MUL))
        else $error("point transfer did not start the multiply phase");

    a_load_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.kind == KIND_LOAD) |=> (r_state == S_IDLE))
        else $error("load transfer started work");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_mag[2] != '0))
        else $error("division running with a zero divisor");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_ZERO_DIV)
        |-> (o_out.result_x == '0 && o_out.result_y == '0))
        else $error("zero-divisor result is not zero");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_SAT)
        |-> (o_out.result_x == 32'sh7fff_ffff || o_out.result_x == 32'sh8000_0000
             || o_out.result_y == 32'sh7fff_ffff || o_out.result_y == 32'sh8000_0000))
        else $error("saturated status without a result at the limit");
`endif

endmodule

// File: verif/tb.sv
// Self-checking testbench for projective_point_transform: coefficient loads and point transfers.
// Depends on ppt_pkg and the ppt_in_if / ppt_out_if interfaces of the block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppt_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int ITEM_TARGET = 1050;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AT     = 100;
    localparam int TAIL_CYCLES = 60;
    localparam logic signed [COEF_W-1:0] ONE = 1 <<< FRAC_BITS;

    typedef struct {
        logic                     kind;
        logic [IDX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [COEF_W-1:0] point_x;
        logic signed [COEF_W-1:0] point_y;
        bit                       hold_for_drain;
    } t_xform_item;

    typedef struct packed {
        logic [QUO_W-1:0]    rx;
        logic [QUO_W-1:0]    ry;
        logic [STATUS_W-1:0] status;
    } t_point_result;

    logic i_clk;
    logic i_rst_n;

    ppt_in_if  in_if ();
    ppt_out_if out_if ();

    projective_point_transform #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    logic signed [COEF_W-1:0] coef_mat [NUM_COEF];
    t_xform_item              item_q [$];
    t_point_result            result_q [$];

    int n_loads, n_ignored, n_points, n_zero_div, n_saturated;
    int n_results, n_mismatch, n_unexpected;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Exact 64-bit weighted sum of one matrix row, each product floored to fixed point.
    function automatic logic signed [63:0] row_sum(input int a, input int b, input int c,
                                                   input logic signed [COEF_W-1:0] px,
                                                   input logic signed [COEF_W-1:0] py);
        logic signed [63:0] ca, cb, cc, xa, yb;
        ca = coef_mat[a];
        cb = coef_mat[b];
        cc = coef_mat[c];
        xa = px;
        yb = py;
        return ((ca * xa) >>> FRAC_BITS) + ((cb * yb) >>> FRAC_BITS) + cc;
    endfunction

    // Returns {saturated, quotient} for num / den in fixed point, truncated toward zero.
    function automatic logic [QUO_W:0] fixed_quotient(input logic signed [63:0] num,
                                                      input logic signed [63:0] den);
        logic [63:0] n_mag, d_mag;
        logic [95:0] q, lim;
        logic        neg, sat;
        n_mag = num[63] ? -num : num;
        d_mag = den[63] ? -den : den;
        neg   = num[63] ^ den[63];
        lim   = neg ? 96'h8000_0000 : 96'h7FFF_FFFF;
        // An integer part that does not fit cannot shrink after the fraction bits are added.
        if ((n_mag / d_mag) >= (64'd1 << (32 - FRAC_BITS)))
            q = lim + 96'd1;
        else
            q = ({32'd0, n_mag} << FRAC_BITS) / {32'd0, d_mag};
        sat = (q > lim);
        if (sat)
            q = lim;
        if (neg)
            q = -q;
        return {sat, q[QUO_W-1:0]};
    endfunction

    function automatic t_point_result project_point(input logic signed [COEF_W-1:0] px,
                                                    input logic signed [COEF_W-1:0] py);
        logic signed [63:0] tx, ty, tw;
        logic [QUO_W:0]     qx, qy;
        t_point_result      r;
        tx = row_sum(0, 3, 6, px, py);
        ty = row_sum(1, 4, 7, px, py);
        tw = row_sum(2, 5, 8, px, py);
        if (tw == 0) begin
            r.rx     = '0;
            r.ry     = '0;
            r.status = ST_ZERO_DIV;
        end else begin
            qx       = fixed_quotient(tx, tw);
            qy       = fixed_quotient(ty, tw);
            r.rx     = qx[QUO_W-1:0];
            r.ry     = qy[QUO_W-1:0];
            r.status = (qx[QUO_W] || qy[QUO_W]) ? ST_SAT : ST_OK;
        end
        return r;
    endfunction

    // Updates the matrix copy for a transferred item and queues the result it owes.
    function automatic void apply_item(input t_xform_item it);
        t_point_result r;
        if (it.kind == KIND_LOAD) begin
            n_loads++;
            if (it.coef_index < NUM_COEF)
                coef_mat[it.coef_index] = it.coef_value;
            else
                n_ignored++;
        end else begin
            n_points++;
            r = project_point(it.point_x, it.point_y);
            if (r.status == ST_ZERO_DIV)
                n_zero_div++;
            if (r.status == ST_SAT)
                n_saturated++;
            result_q.push_back(r);
        end
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_fixed();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            return $urandom;
        if (pick < 85)
            return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        case ($urandom_range(0, 6))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 0;
            3:       return 1;
            4:       return -1;
            5:       return ONE;
            default: return -ONE;
        endcase
    endfunction

    function automatic t_xform_item load_item(input int slot, input logic signed [COEF_W-1:0] v);
        t_xform_item it;
        it.kind           = KIND_LOAD;
        it.coef_index     = IDX_W'(slot);
        it.coef_value     = v;
        it.point_x        = $urandom;
        it.point_y        = $urandom;
        it.hold_for_drain = 1'b0;
        return it;
    endfunction

    function automatic t_xform_item point_item(input logic signed [COEF_W-1:0] px,
                                               input logic signed [COEF_W-1:0] py);
        t_xform_item it;
        it.kind           = KIND_POINT;
        it.coef_index     = IDX_W'($urandom_range(0, 15));
        it.coef_value     = $urandom;
        it.point_x        = px;
        it.point_y        = py;
        it.hold_for_drain = 1'b0;
        return it;
    endfunction

    function automatic int next_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    // Sender: offers queued items, holding each until its transfer completes.
    t_xform_item offered;
    int          tx_gap;
    bit          tx_burst;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            tx_gap      = 0;
            tx_burst    = 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                apply_item(offered);
                if ($urandom_range(0, 39) == 0)
                    tx_burst = !tx_burst;
                tx_gap = next_gap(tx_burst);
            end
            if (!in_if.valid || in_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_if.valid <= 1'b0;
                end else if (item_q.size() > 0 &&
                             !(item_q[0].hold_for_drain && result_q.size() > 0)) begin
                    offered = item_q.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.kind       <= offered.kind;
                    in_if.coef_index <= offered.coef_index;
                    in_if.coef_value <= offered.coef_value;
                    in_if.point_x    <= offered.point_x;
                    in_if.point_y    <= offered.point_y;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transfer against the oldest prediction.
    int rx_gap;
    bit rx_burst;

    always @(posedge i_clk) begin
        t_point_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_gap       = 0;
            rx_burst     = 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_results++;
                if (result_q.size() == 0) begin
                    n_unexpected++;
                    if (n_unexpected + n_mismatch <= 10)
                        $display("unexpected result x=%h y=%h status=%0d",
                                 out_if.result_x, out_if.result_y, out_if.status);
                end else begin
                    want = result_q.pop_front();
                    if (out_if.result_x !== want.rx || out_if.result_y !== want.ry ||
                        out_if.status !== want.status) begin
                        n_mismatch++;
                        if (n_unexpected + n_mismatch <= 10)
                            $display("result %0d: exp x=%h y=%h st=%0d, got x=%h y=%h st=%0d",
                                     n_results, want.rx, want.ry, want.status,
                                     out_if.result_x, out_if.result_y, out_if.status);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                // One long hold-off lets the block fill up and push back on its input.
                rx_gap = (n_results == HOLD_AT) ? LONG_HOLD : next_gap(rx_burst);
            end
            if (rx_gap > 0) begin
                rx_gap--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned pick;
        int          slot;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.kind       = KIND_LOAD;
        in_if.coef_index = '0;
        in_if.coef_value = '0;
        in_if.point_x    = '0;
        in_if.point_y    = '0;
        out_if.ready     = 1'b0;
        foreach (coef_mat[i])
            coef_mat[i] = 0;
        coef_mat[0] = ONE;
        coef_mat[4] = ONE;
        coef_mat[8] = ONE;

        // Directed part: identity, extremes, ignored slots, zero divisor and saturation.
        item_q.push_back(point_item(32'sh0001_8000, -32'sh0002_4000));
        item_q.push_back(point_item(32'sh7FFF_FFFF, 32'sh8000_0000));
        item_q.push_back(point_item(32'sh8000_0000, 32'sh7FFF_FFFF));
        item_q.push_back(point_item(0, 0));
        item_q.push_back(load_item(9, 0));
        item_q.push_back(load_item(15, 32'sh7FFF_FFFF));
        item_q.push_back(point_item(32'sh0003_0000, 32'sh0005_0000));
        item_q.push_back(load_item(6, 32'sh0002_8000));
        item_q.push_back(load_item(7, -ONE));
        item_q.push_back(point_item(ONE, ONE));
        item_q.push_back(load_item(8, 0));
        item_q.push_back(point_item(0, 0));
        item_q.push_back(point_item(ONE, 0));
        item_q.push_back(load_item(8, 1));
        item_q.push_back(point_item(32'sh0064_0000, 0));
        item_q.push_back(point_item(-32'sh0064_0000, 0));
        item_q.push_back(load_item(0, 32'sh8000_0000));
        item_q.push_back(load_item(4, 32'sh7FFF_FFFF));
        item_q.push_back(load_item(8, ONE));
        item_q.push_back(point_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        item_q.push_back(load_item(2, 32'sh0000_8000));
        item_q.push_back(point_item(32'sh0002_0000, 32'sh0003_0000));
        item_q.push_back(point_item(-32'sh0002_0000, 32'sh8000_0000));

        // The sender waits for every outstanding result before the random part starts.
        item_q.push_back(point_item(rand_fixed(), rand_fixed()));
        item_q[item_q.size()-1].hold_for_drain = 1'b1;

        while (item_q.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                item_q.push_back(point_item(rand_fixed(), rand_fixed()));
            end else if (pick < 80) begin
                slot = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                   : $urandom_range(0, 8);
                item_q.push_back(load_item(slot, rand_fixed()));
            end else if (pick < 85) begin
                // Clear the w row so the next point has a zero divisor.
                item_q.push_back(load_item(2, 0));
                item_q.push_back(load_item(5, 0));
                item_q.push_back(load_item(8, 0));
                item_q.push_back(point_item(rand_fixed(), rand_fixed()));
            end else if (pick < 89) begin
                item_q.push_back(point_item(0, 0));
            end else begin
                // A well-formed perspective matrix followed by a few ordinary points.
                for (int i = 0; i < NUM_COEF; i++) begin
                    if (i == 2 || i == 5)
                        item_q.push_back(load_item(i, int'($urandom_range(0, 2000)) - 1000));
                    else if (i == 8)
                        item_q.push_back(load_item(i, ONE + int'($urandom_range(0, 65536))
                                                         - 32768));
                    else
                        item_q.push_back(load_item(i, int'($urandom_range(0, 32'h0008_0000))
                                                         - 32'sh0004_0000));
                end
                for (int i = 0; i < 3; i++)
                    item_q.push_back(point_item(
                        int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000,
                        int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (item_q.size() != 0 || in_if.valid || result_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d coefficient loads (%0d to unused slots) and %0d points.",
                 n_loads, n_ignored, n_points);
        $display("Points with zero divisor: %0d, saturated: %0d; results checked: %0d.",
                 n_zero_div, n_saturated, n_results);
        if (n_mismatch == 0 && n_unexpected == 0 && result_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d items unsent and %0d results outstanding.",
                 item_q.size(), result_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/ppt_pkg.sv
hdl/ppt_if.sv
hdl/ppt_div.sv
hdl/projective_point_transform.sv
verif/tb.sv
